// ----- design/romaji_to_kana_converter_top_macros.svh -----
// Assertion helpers shared by the converter RTL.
`ifndef ROMAJI_TO_KANA_CONVERTER_TOP_MACROS_SVH
`define ROMAJI_TO_KANA_CONVERTER_TOP_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define RKC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rkc_pkg.sv -----
package rkc_pkg;

    // Edit commands carried with each result item
    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_NEWLINE = 3'd2,
        CMD_LEFT    = 3'd3,
        CMD_RIGHT   = 3'd4,
        CMD_UP      = 3'd5,
        CMD_DOWN    = 3'd6
    } cmd_t;

    // Input modes
    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_HIRA   = 2'd1;
    localparam logic [1:0] MODE_KATA   = 2'd2;

    // Keyboard usage codes
    localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
    localparam logic [7:0] KEY_LEFT      = 8'h50;
    localparam logic [7:0] KEY_RIGHT     = 8'h4F;
    localparam logic [7:0] KEY_UP        = 8'h52;
    localparam logic [7:0] KEY_DOWN      = 8'h51;

    // Characters with a special role
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_A  = 8'h61;
    localparam logic [7:0] CHAR_I  = 8'h69;
    localparam logic [7:0] CHAR_U  = 8'h75;
    localparam logic [7:0] CHAR_E  = 8'h65;
    localparam logic [7:0] CHAR_O  = 8'h6F;
    localparam logic [7:0] CHAR_J  = 8'h6A;
    localparam logic [7:0] CHAR_L  = 8'h6C;
    localparam logic [7:0] CHAR_Q  = 8'h71;
    localparam logic [7:0] CHAR_N  = 8'h6E;
    localparam logic [7:0] CHAR_Y  = 8'h79;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Special rows and columns of the kana table
    localparam logic [4:0] ROW_PLAIN   = 5'd0;
    localparam logic [4:0] ROW_SMALL_Y = 5'd15;
    localparam logic [4:0] ROW_SPECIAL = 5'd16;
    localparam logic [4:0] ROW_SMALL   = 5'd17;
    localparam logic [2:0] COL_A       = 3'd0;
    localparam logic [2:0] COL_I       = 3'd1;
    localparam logic [2:0] COL_U       = 3'd2;
    localparam logic [2:0] COL_E       = 3'd3;
    localparam logic [2:0] COL_O       = 3'd4;
    localparam logic [2:0] COL_TSU     = 3'd0;
    localparam logic [2:0] COL_N       = 3'd1;
    localparam int unsigned ROW_LEN    = 5;
    localparam int unsigned KATA_BASE  = 90;
    localparam int unsigned ROM_DEPTH  = 180;

    // Result queue geometry
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] code_point;
        logic [1:0]  input_mode;
        logic        last;
    } res_t;

    // Hiragana rows 0..17, then katakana rows 0..17, five vowels per row
    localparam logic [15:0] KANA_ROM [0:ROM_DEPTH-1] = '{
        16'h3042,16'h3044,16'h3046,16'h3048,16'h304A,16'h304B,16'h304D,16'h304F,16'h3051,16'h3053,
        16'h3055,16'h3057,16'h3059,16'h305B,16'h305D,16'h305F,16'h3061,16'h3064,16'h3066,16'h3068,
        16'h306A,16'h306B,16'h306C,16'h306D,16'h306E,16'h306F,16'h3072,16'h3075,16'h3078,16'h307B,
        16'h307E,16'h307F,16'h3080,16'h3081,16'h3082,16'h3084,16'h3044,16'h3086,16'h3048,16'h3088,
        16'h3089,16'h308A,16'h308B,16'h308C,16'h308D,16'h308F,16'h3044,16'h3046,16'h3048,16'h3092,
        16'h304C,16'h304E,16'h3050,16'h3052,16'h3054,16'h3056,16'h3058,16'h305A,16'h305C,16'h305E,
        16'h3060,16'h3062,16'h3065,16'h3067,16'h3069,16'h3070,16'h3073,16'h3076,16'h3079,16'h307C,
        16'h3071,16'h3074,16'h3077,16'h307A,16'h307D,16'h3083,16'h3043,16'h3085,16'h3047,16'h3087,
        16'h3063,16'h3093,16'h002D,16'h002D,16'h002D,16'h3041,16'h3043,16'h3045,16'h3047,16'h3049,
        16'h30A2,16'h30A4,16'h30A6,16'h30A8,16'h30AA,16'h30AB,16'h30AD,16'h30AF,16'h30B1,16'h30B3,
        16'h30B5,16'h30B7,16'h30B9,16'h30BB,16'h30BD,16'h30BF,16'h30C1,16'h30C4,16'h30C6,16'h30C8,
        16'h30CA,16'h30CB,16'h30CC,16'h30CD,16'h30CE,16'h30CF,16'h30D2,16'h30D5,16'h30D8,16'h30DB,
        16'h30DE,16'h30DF,16'h30E0,16'h30E1,16'h30E2,16'h30E4,16'h30A4,16'h30E6,16'h30A8,16'h30E8,
        16'h30E9,16'h30EA,16'h30EB,16'h30EC,16'h30ED,16'h30EF,16'h30A4,16'h30A6,16'h30A8,16'h30F2,
        16'h30AC,16'h30AE,16'h30B0,16'h30B2,16'h30B4,16'h30B6,16'h30B8,16'h30BA,16'h30BC,16'h30BE,
        16'h30C0,16'h30C2,16'h30C5,16'h30C7,16'h30C9,16'h30D0,16'h30D3,16'h30D6,16'h30D9,16'h30DC,
        16'h30D1,16'h30D4,16'h30D7,16'h30DA,16'h30DD,16'h30E3,16'h30A3,16'h30E5,16'h30A7,16'h30E7,
        16'h30C3,16'h30F3,16'h002D,16'h002D,16'h002D,16'h30A1,16'h30A3,16'h30A5,16'h30A7,16'h30A9
    };

    // Kana table row of a supported consonant letter, zero for any other character
    function automatic logic [4:0] consonant_row(input logic [7:0] c);
        logic [4:0] row;
        case (c)
            8'h6B:   row = 5'd1;   // k
            8'h73:   row = 5'd2;   // s
            8'h74:   row = 5'd3;   // t
            8'h6E:   row = 5'd4;   // n
            8'h68:   row = 5'd5;   // h
            8'h6D:   row = 5'd6;   // m
            8'h79:   row = 5'd7;   // y
            8'h72:   row = 5'd8;   // r
            8'h77:   row = 5'd9;   // w
            8'h67:   row = 5'd10;  // g
            8'h7A:   row = 5'd11;  // z
            8'h64:   row = 5'd12;  // d
            8'h62:   row = 5'd13;  // b
            8'h70:   row = 5'd14;  // p
            8'h78:   row = ROW_SMALL;  // x
            default: row = ROW_PLAIN;
        endcase
        return row;
    endfunction

    // Table lookup; katakana half sits after the hiragana half
    function automatic logic [15:0] kana_lookup(input logic [4:0] row,
                                                input logic [2:0] col,
                                                input logic       kata);
        logic [7:0] idx;
        idx = 8'(row) * 8'(ROW_LEN) + 8'(col);
        if (kata) begin
            idx = idx + 8'(KATA_BASE);
        end
        return KANA_ROM[idx];
    endfunction

endpackage

// ----- design/romaji_to_kana_converter_top.sv -----
// Romaji-to-kana keystroke converter. One keystroke item (usage code and
// character in s_axis_tdata, ctrl flag in s_axis_tuser) is taken per cycle
// while s_axis_tready is high and turned in that same cycle into zero, one
// or two edit-command items, which are written to a four-entry result queue
// and are registered there before they appear on m_axis. Results leave one
// per cycle while m_axis_tready is high, so a key that yields two results
// is sent as two items. s_axis_tready is high while the queue has room for
// two results. Mode and pending consonant state update at the accepting edge;
// m_axis_tlast marks the last result of a key.
`include "romaji_to_kana_converter_top_macros.svh"

module romaji_to_kana_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] key_code, [15:8] char_code
    input  logic        s_axis_tuser,   // [0] ctrl
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] command, [18:3] code_point,
                                        // [20:19] input_mode, [23:21] zero
    output logic        m_axis_tlast
);

    // Converter state
    logic [1:0] mode_reg,  mode_next;
    logic [7:0] cons_reg,  cons_next;
    logic       pal_reg,   pal_next;

    // Result queue
    rkc_pkg::res_t                fifo_reg [0:rkc_pkg::FIFO_DEPTH-1];
    logic [rkc_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rkc_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rkc_pkg::FIFO_AW:0]    count_reg,  count_next;

    logic [7:0]      key_code;
    logic [7:0]      char_code;
    logic            ctrl;
    logic [7:0]      ch_fold;
    logic [4:0]      fold_row;
    logic [4:0]      pend_row;
    logic            is_vowel;
    logic [2:0]      vowel_col;
    logic            kata;
    logic [1:0]      n_emit;
    rkc_pkg::cmd_t   e0_cmd;
    logic [15:0]     e0_cp;
    logic [15:0]     e1_cp;
    logic            s_accept;
    logic            m_pop;
    logic [1:0]      n_push;
    rkc_pkg::res_t   head;

    assign key_code  = s_axis_tdata[7:0];
    assign char_code = s_axis_tdata[15:8];
    assign ctrl      = s_axis_tuser;
    assign kata      = (mode_reg == rkc_pkg::MODE_KATA);
    assign pend_row  = rkc_pkg::consonant_row(cons_reg);
    assign fold_row  = rkc_pkg::consonant_row(ch_fold);

    // Uppercase folding
    always_comb begin
        if (char_code >= rkc_pkg::CHAR_UC_A && char_code <= rkc_pkg::CHAR_UC_Z) begin
            ch_fold = char_code + rkc_pkg::CASE_OFFSET;
        end else begin
            ch_fold = char_code;
        end
    end

    // Vowel decode
    always_comb begin
        is_vowel  = 1'b1;
        vowel_col = rkc_pkg::COL_A;
        case (ch_fold)
            rkc_pkg::CHAR_A: vowel_col = rkc_pkg::COL_A;
            rkc_pkg::CHAR_I: vowel_col = rkc_pkg::COL_I;
            rkc_pkg::CHAR_U: vowel_col = rkc_pkg::COL_U;
            rkc_pkg::CHAR_E: vowel_col = rkc_pkg::COL_E;
            rkc_pkg::CHAR_O: vowel_col = rkc_pkg::COL_O;
            default:         is_vowel  = 1'b0;
        endcase
    end

    // Keystroke decode: next state and up to two results
    always_comb begin
        mode_next = mode_reg;
        cons_next = cons_reg;
        pal_next  = pal_reg;
        n_emit    = 2'd0;
        e0_cmd    = rkc_pkg::CMD_INSERT;
        e0_cp     = 16'h0000;
        e1_cp     = 16'h0000;
        case (key_code)
            rkc_pkg::KEY_BACKSPACE: begin
                // pending palatal, then pending consonant, go first
                if (pal_reg) begin
                    pal_next = 1'b0;
                end else if (cons_reg != 8'h00) begin
                    cons_next = 8'h00;
                end else begin
                    n_emit = 2'd1;
                    e0_cmd = rkc_pkg::CMD_DELETE;
                end
            end
            rkc_pkg::KEY_LEFT: begin
                n_emit = 2'd1;
                e0_cmd = rkc_pkg::CMD_LEFT;
            end
            rkc_pkg::KEY_RIGHT: begin
                n_emit = 2'd1;
                e0_cmd = rkc_pkg::CMD_RIGHT;
            end
            rkc_pkg::KEY_UP: begin
                n_emit = 2'd1;
                e0_cmd = rkc_pkg::CMD_UP;
            end
            rkc_pkg::KEY_DOWN: begin
                n_emit = 2'd1;
                e0_cmd = rkc_pkg::CMD_DOWN;
            end
            default: begin
                if (char_code == rkc_pkg::CHAR_CR) begin
                    n_emit = 2'd1;
                    e0_cmd = rkc_pkg::CMD_NEWLINE;
                end else if (ctrl) begin
                    if (char_code == rkc_pkg::CHAR_J) begin
                        mode_next = rkc_pkg::MODE_HIRA;
                    end
                end else if (mode_reg == rkc_pkg::MODE_DIRECT) begin
                    n_emit = 2'd1;
                    e0_cp  = {8'h00, char_code};
                end else if (is_vowel) begin
                    // vowel completes a kana; palatal gives the i-column kana plus a small-y row kana
                    cons_next = 8'h00;
                    pal_next  = 1'b0;
                    if (pal_reg) begin
                        n_emit = 2'd2;
                        e0_cp  = rkc_pkg::kana_lookup(pend_row, rkc_pkg::COL_I, kata);
                        e1_cp  = rkc_pkg::kana_lookup(rkc_pkg::ROW_SMALL_Y, vowel_col, kata);
                    end else begin
                        n_emit = 2'd1;
                        e0_cp  = rkc_pkg::kana_lookup(pend_row, vowel_col, kata);
                    end
                end else if (ch_fold == rkc_pkg::CHAR_L) begin
                    mode_next = rkc_pkg::MODE_DIRECT;
                end else if (ch_fold == rkc_pkg::CHAR_Q) begin
                    mode_next = rkc_pkg::MODE_KATA;
                end else if (fold_row != rkc_pkg::ROW_PLAIN) begin
                    if (cons_reg == ch_fold) begin
                        // doubled consonant: n kana for nn, else small tsu
                        n_emit = 2'd1;
                        if (ch_fold == rkc_pkg::CHAR_N) begin
                            e0_cp     = rkc_pkg::kana_lookup(rkc_pkg::ROW_SPECIAL,
                                                             rkc_pkg::COL_N, kata);
                            cons_next = 8'h00;
                            pal_next  = 1'b0;
                        end else begin
                            e0_cp = rkc_pkg::kana_lookup(rkc_pkg::ROW_SPECIAL,
                                                         rkc_pkg::COL_TSU, kata);
                        end
                    end else if (ch_fold == rkc_pkg::CHAR_Y && cons_reg != 8'h00) begin
                        pal_next = 1'b1;
                    end else begin
                        // new consonant; a pending n is flushed as the n kana
                        if (cons_reg == rkc_pkg::CHAR_N) begin
                            n_emit = 2'd1;
                            e0_cp  = rkc_pkg::kana_lookup(rkc_pkg::ROW_SPECIAL,
                                                          rkc_pkg::COL_N, kata);
                        end
                        cons_next = ch_fold;
                    end
                end else begin
                    n_emit = 2'd1;
                    e0_cp  = {8'h00, ch_fold};
                end
            end
        endcase
    end

    // Handshakes and queue bookkeeping
    assign s_axis_tready = (count_reg <= (rkc_pkg::FIFO_AW + 1)'(rkc_pkg::FIFO_DEPTH - 2));
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign m_pop         = m_axis_tvalid & m_axis_tready;
    assign n_push        = s_accept ? n_emit : 2'd0;

    assign wr_ptr_next = wr_ptr_reg + rkc_pkg::FIFO_AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + rkc_pkg::FIFO_AW'(m_pop);
    assign count_next  = count_reg + (rkc_pkg::FIFO_AW + 1)'(n_push)
                                   - (rkc_pkg::FIFO_AW + 1)'(m_pop);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= rkc_pkg::MODE_HIRA;
            cons_reg   <= 8'h00;
            pal_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_accept) begin
                mode_reg <= mode_next;
                cons_reg <= cons_next;
                pal_reg  <= pal_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= '{command:    e0_cmd,
                                      code_point: e0_cp,
                                      input_mode: mode_next,
                                      last:       (n_push == 2'd1)};
        end
        if (n_push == 2'd2) begin
            fifo_reg[wr_ptr_reg + rkc_pkg::FIFO_AW'(1)] <= '{command:    rkc_pkg::CMD_INSERT,
                                                             code_point: e1_cp,
                                                             input_mode: mode_next,
                                                             last:       1'b1};
        end
    end

    // Output from the queue head
    assign head         = fifo_reg[rd_ptr_reg];
    assign m_axis_tdata = {3'b000, head.input_mode, head.code_point, head.command};
    assign m_axis_tlast = head.last;

    // Checks
    `RKC_ASSERT_ALWAYS(a_count_bound, count_reg <= (rkc_pkg::FIFO_AW + 1)'(rkc_pkg::FIFO_DEPTH), "result queue overflow")
    `RKC_ASSERT_ALWAYS(a_pal_needs_cons, !pal_reg || (cons_reg != 8'h00), "palatal pending without consonant")
    `RKC_ASSERT_ALWAYS(a_mode_legal, mode_reg != 2'd3, "unreachable input mode")
    `RKC_ASSERT_NEXT(a_drain_empty, m_pop && (count_reg == 3'd1) && !(s_accept && (n_emit != 2'd0)), !m_axis_tvalid, "queue not empty after last pop")

endmodule
